// ----- hw/rtl/fraction_reduce_assert.svh -----
// Assertion macros for the fraction reduction block
`ifndef FRACTION_REDUCE_ASSERT_SVH
`define FRACTION_REDUCE_ASSERT_SVH

// cond must hold at every clock edge out of reset
`define FR_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// when trig holds, res must hold in the next cycle
`define FR_ASSERT_NEXT(lbl, trig, res, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (res)) else $error(msg);

`endif

// ----- hw/rtl/fr_pkg.sv -----
package fr_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int CNT_W = $clog2(DATA_WIDTH);
	localparam int IN_TDATA_W = ((2 * DATA_WIDTH + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((2 * DATA_WIDTH - 1 + 7) / 8) * 8;
	localparam int OUT_TUSER_W = 2;

	typedef logic [DATA_WIDTH-1:0] mag_t;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_GCD  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	localparam logic [1:0] PH_GCD = 2'd0;
	localparam logic [1:0] PH_NUM = 2'd1;
	localparam logic [1:0] PH_DEN = 2'd2;

endpackage

// ----- hw/rtl/fraction_reduce.sv -----
// Fraction reduction to lowest terms.
// Input channel s_axis: one item is a signed fraction, numerator in the low
// half of tdata, denominator in the high half. Output channel m_axis: one
// item per input item, reduced numerator and positive reduced denominator
// in tdata, flags is_whole and zero_denominator in tuser.
// All arithmetic runs on one restoring divider that produces one quotient
// bit per cycle. The Euclidean loop takes k divisions (k about 1 to 46 at
// 32 bits), then the two parts are divided by the common divisor. An item
// with a zero numerator or zero denominator skips the divider.
// One item is worked on at a time; s_axis_tready is high only while the
// divider is free. A finished item waits in the output register while the
// next input is taken; if the receiver stalls m_axis_tready, the output item
// holds and the block stops after finishing the item behind it.
// Reset clears the control state and the output valid flag; the block is
// ready for an item in the first cycle after reset is released.
module fraction_reduce
	import fr_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // numerator, denominator
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // reduced_numerator, reduced_denominator
	output logic [OUT_TUSER_W-1:0] m_axis_tuser   // is_whole, zero_denominator
);

	logic [1:0]            st_q;
	logic [1:0]            ph_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  out_valid_q;

	logic                  neg_q;
	mag_t                  nmag_q;
	mag_t                  dmag_q;
	mag_t                  p_q;
	mag_t                  q_q;
	mag_t                  dvd_q;
	mag_t                  dvs_q;
	mag_t                  rem_q;
	mag_t                  rn_q;
	mag_t                  res_num_q;
	logic [DATA_WIDTH-2:0] res_den_q;
	logic                  res_whole_q;
	logic                  res_zd_q;
	logic [OUT_TDATA_W-1:0] out_data_q;
	logic [OUT_TUSER_W-1:0] out_user_q;

	mag_t                  in_num;
	mag_t                  in_den;
	mag_t                  in_nmag;
	mag_t                  in_dmag;
	logic                  in_acc;
	logic [DATA_WIDTH:0]   sh;
	logic [DATA_WIDTH:0]   diff;
	logic                  ge;
	mag_t                  rem_n;
	mag_t                  dvd_n;
	logic                  div_last;
	logic                  out_free;

	assign in_num  = s_axis_tdata[DATA_WIDTH-1:0];
	assign in_den  = s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
	assign in_nmag = in_num[DATA_WIDTH-1] ? (~in_num) + mag_t'(1) : in_num;
	assign in_dmag = in_den[DATA_WIDTH-1] ? (~in_den) + mag_t'(1) : in_den;

	assign s_axis_tready = (st_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	assign sh       = {rem_q, dvd_q[DATA_WIDTH-1]};
	assign diff     = sh - {1'b0, dvs_q};
	assign ge       = !diff[DATA_WIDTH];
	assign rem_n    = ge ? diff[DATA_WIDTH-1:0] : sh[DATA_WIDTH-1:0];
	assign dvd_n    = {dvd_q[DATA_WIDTH-2:0], ge};
	assign div_last = (cnt_q == CNT_W'(DATA_WIDTH - 1));
	assign out_free = !out_valid_q || m_axis_tready;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			ph_q        <= PH_GCD;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_axis_tready && st_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (in_dmag == '0 || in_nmag == '0) begin
							st_q <= ST_DONE;
						end else begin
							st_q <= ST_GCD;
							ph_q <= PH_GCD;
						end
					end
				end
				ST_GCD: begin
					st_q  <= ST_DIV;
					cnt_q <= '0;
					if (q_q == '0) begin
						ph_q <= PH_NUM;
					end
				end
				ST_DIV: begin
					if (div_last) begin
						cnt_q <= '0;
						unique case (ph_q)
							PH_GCD: st_q <= ST_GCD;
							PH_NUM: ph_q <= PH_DEN;
							default: st_q <= ST_DONE;
						endcase
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				default: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						st_q        <= ST_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				if (in_acc) begin
					neg_q       <= in_num[DATA_WIDTH-1] ^ in_den[DATA_WIDTH-1];
					nmag_q      <= in_nmag;
					dmag_q      <= in_dmag;
					p_q         <= in_nmag;
					q_q         <= in_dmag;
					res_num_q   <= '0;
					res_zd_q    <= (in_dmag == '0);
					res_whole_q <= (in_dmag != '0);
					res_den_q   <= (in_dmag == '0) ? '0 : (DATA_WIDTH-1)'(1);
				end
			end
			ST_GCD: begin
				rem_q <= '0;
				if (q_q == '0) begin
					dvd_q <= nmag_q;
					dvs_q <= p_q;
				end else begin
					dvd_q <= p_q;
					dvs_q <= q_q;
				end
			end
			ST_DIV: begin
				if (!(div_last && ph_q == PH_NUM)) begin
					rem_q <= rem_n;
					dvd_q <= dvd_n;
				end
				if (div_last) begin
					unique case (ph_q)
						PH_GCD: begin
							p_q <= dvs_q;
							q_q <= rem_n;
						end
						PH_NUM: begin
							rn_q  <= dvd_n;
							dvd_q <= dmag_q;
							rem_q <= '0;
						end
						default: begin
							if (neg_q) begin
								res_num_q <= (~rn_q) + mag_t'(1);
							end else if (rn_q[DATA_WIDTH-1]) begin
								res_num_q <= {1'b0, {(DATA_WIDTH-1){1'b1}}};
							end else begin
								res_num_q <= rn_q;
							end
							res_den_q   <= dvd_n[DATA_WIDTH-1] ? '1 : dvd_n[DATA_WIDTH-2:0];
							res_whole_q <= (dvd_n == mag_t'(1));
							res_zd_q    <= 1'b0;
						end
					endcase
				end
			end
			default: begin
				if (out_free) begin
					out_data_q <= OUT_TDATA_W'({res_den_q, res_num_q});
					out_user_q <= {res_zd_q, res_whole_q};
				end
			end
		endcase
	end

endmodule

// ----- hw/rtl/fr_chk.sv -----
`include "fraction_reduce_assert.svh"

module fr_chk
	import fr_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input logic [OUT_TUSER_W-1:0] m_axis_tuser
);

	logic [DATA_WIDTH-2:0] den;

	assign den = m_axis_tdata[2*DATA_WIDTH-2:DATA_WIDTH];

	`FR_ASSERT_ALWAYS(a_err_zero, !(m_axis_tvalid && m_axis_tuser[1]) || (m_axis_tdata == '0 && !m_axis_tuser[0]), "error item must carry zero data")
	`FR_ASSERT_ALWAYS(a_den_nz, !(m_axis_tvalid && !m_axis_tuser[1]) || (den != '0), "valid item has zero denominator")
	`FR_ASSERT_ALWAYS(a_whole, !(m_axis_tvalid && !m_axis_tuser[1]) || (m_axis_tuser[0] == (den == (DATA_WIDTH-1)'(1))), "whole flag disagrees with denominator")
	`FR_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled output item changed")
	`FR_ASSERT_NEXT(a_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while an item is in work")

endmodule

bind fraction_reduce fr_chk u_fr_chk (.*);
